// ===== src/mstk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared constants and types for the min-tracking stack.
// ----------------------------------------------------------------------------
package mstk_pkg;

    localparam int DEPTH   = 256;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int ENTRY_W = WORD_W + 2;

    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [CNT_W-1:0]          count_t;

    // Operation codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    // Read and write requests toward the entry memory
    typedef struct packed {
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
        logic   rd_en;
        addr_t  rd_addr;
    } ram_req_t;

endpackage

// ===== src/mstk_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_entry_ram
// Single-write, single-read synchronous memory for stack entries.
// Read data is registered and appears in the cycle after the read request.
// ----------------------------------------------------------------------------
module mstk_entry_ram (
    input  logic              clk,
    input  mstk_pkg::ram_req_t req,
    output mstk_pkg::entry_t   rd_data
);

    mstk_pkg::entry_t mem [mstk_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== src/min_tracking_stack_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Stack of signed 32-bit values that also reports its minimum, using a
// single minimum register and encoded entries instead of a second stack.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | kind, push_value
// out      | out_valid / out_ready| top_value, min_value, is_empty, status
//
// Results: a push, a rejected op, or a pop that empties the stack produces its
//   result in the cycle after acceptance. A pop that leaves entries needs the
//   new top from the entry memory, so its result passes through the S_POP
//   state before it reaches the output register.
// Reset: count cleared, minimum set to the largest positive value; the entry
//   memory needs no clearing since only written entries are ever used.
// Stalls: one transaction is in flight at a time; a new item is taken in the
//   cycle its predecessor's result leaves the output register.
// ----------------------------------------------------------------------------
module min_tracking_stack_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic signed [31:0]       push_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [31:0]       top_value,
    output logic signed [31:0]       min_value,
    output logic                     is_empty,
    output logic [1:0]               status
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t              state_reg;
    mstk_pkg::count_t    count_reg;
    mstk_pkg::word_t     min_reg;
    mstk_pkg::entry_t    top_reg;     // copy of the encoded top entry
    logic                out_valid_reg;
    logic                out_valid_next;
    mstk_pkg::word_t     top_value_reg;
    mstk_pkg::word_t     min_value_reg;
    logic                is_empty_reg;
    mstk_pkg::status_t   status_reg;

    mstk_pkg::ram_req_t  ram_req;
    mstk_pkg::entry_t    ram_rd_data;

    logic                accept;
    logic                is_full;
    logic                is_zero;
    mstk_pkg::entry_t    x_ext;
    mstk_pkg::entry_t    min_ext;
    mstk_pkg::entry_t    encoded;
    mstk_pkg::entry_t    restored;
    logic                x_below_min;
    logic                top_encoded;
    mstk_pkg::count_t    count_dec;
    mstk_pkg::word_t     new_min_pop;
    logic                pop_waits;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;

    assign is_full   = (count_reg == mstk_pkg::count_t'(mstk_pkg::DEPTH));
    assign is_zero   = (count_reg == '0);
    assign count_dec = count_reg - mstk_pkg::count_t'(1);

    // Sign-extended operands; all encoding math fits 34 bits.
    assign x_ext       = mstk_pkg::entry_t'(push_value);
    assign min_ext     = mstk_pkg::entry_t'(min_reg);
    assign x_below_min = (x_ext < min_ext);
    assign encoded     = (x_ext <<< 1) - min_ext;

    // Top entry below the minimum marks an encoded entry.
    assign top_encoded     = (top_reg < min_ext);
    assign restored        = (min_ext <<< 1) - top_reg;
    assign new_min_pop     = top_encoded ? restored[mstk_pkg::WORD_W-1:0] : min_reg;

    // Pop that leaves entries: its result waits for the memory read.
    assign pop_waits = (kind == mstk_pkg::KIND_POP) && !is_zero && (count_dec != '0);

    // Result register: loaded when a result is formed, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (state_reg == S_POP)
        begin
            out_valid_next = 1'b1;
        end
        else if (accept && !pop_waits)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Memory requests: write on push, read the entry below the top on pop.
    always_comb
    begin
        ram_req.wr_en   = accept && (kind == mstk_pkg::KIND_PUSH) && !is_full;
        ram_req.wr_addr = count_reg[mstk_pkg::ADDR_W-1:0];
        ram_req.wr_data = (is_zero || !x_below_min) ? x_ext : encoded;
        ram_req.rd_en   = accept && (kind == mstk_pkg::KIND_POP) && !is_zero;
        ram_req.rd_addr = count_dec[mstk_pkg::ADDR_W-1:0] - mstk_pkg::addr_t'(1);
    end

    mstk_entry_ram u_entry_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            min_reg       <= 32'sh7FFF_FFFF;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            top_value_reg <= '0;
            min_value_reg <= '0;
            is_empty_reg  <= 1'b1;
            status_reg    <= mstk_pkg::ST_OK;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (kind == mstk_pkg::KIND_PUSH)
                        begin
                            if (is_full)
                            begin
                                // Dropped; report the unchanged stack.
                                status_reg    <= mstk_pkg::ST_PUSH_FULL;
                                is_empty_reg  <= 1'b0;
                                min_value_reg <= min_reg;
                                top_value_reg <= top_encoded ? min_reg
                                                 : top_reg[mstk_pkg::WORD_W-1:0];
                            end
                            else
                            begin
                                status_reg    <= mstk_pkg::ST_OK;
                                is_empty_reg  <= 1'b0;
                                count_reg     <= count_reg + mstk_pkg::count_t'(1);
                                top_reg       <= ram_req.wr_data;
                                top_value_reg <= push_value;
                                if (is_zero || x_below_min)
                                begin
                                    min_reg       <= push_value;
                                    min_value_reg <= push_value;
                                end
                                else
                                begin
                                    min_value_reg <= min_reg;
                                end
                            end
                        end
                        else if (is_zero)
                        begin
                            // Pop on empty is ignored.
                            status_reg    <= mstk_pkg::ST_POP_EMPTY;
                            is_empty_reg  <= 1'b1;
                            top_value_reg <= '0;
                            min_value_reg <= '0;
                        end
                        else
                        begin
                            count_reg <= count_dec;
                            min_reg   <= new_min_pop;
                            if (count_dec == '0)
                            begin
                                status_reg    <= mstk_pkg::ST_OK;
                                is_empty_reg  <= 1'b1;
                                top_value_reg <= '0;
                                min_value_reg <= '0;
                            end
                            else
                            begin
                                // Wait for the new top from memory.
                                state_reg <= S_POP;
                            end
                        end
                    end
                end

                S_POP:
                begin
                    state_reg     <= S_IDLE;
                    top_reg       <= ram_rd_data;
                    status_reg    <= mstk_pkg::ST_OK;
                    is_empty_reg  <= 1'b0;
                    min_value_reg <= min_reg;
                    top_value_reg <= (ram_rd_data < mstk_pkg::entry_t'(min_reg)) ? min_reg
                                     : ram_rd_data[mstk_pkg::WORD_W-1:0];
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign top_value = top_value_reg;
    assign min_value = min_value_reg;
    assign is_empty  = is_empty_reg;
    assign status    = status_reg;

endmodule
